### hw/rtl/drt_pkg.sv
// Shared constants and field widths for the dense rank table.
`timescale 1ns / 1ps
`default_nettype none

package drt_pkg;

	localparam int FUNC_W   = 2;
	localparam int VALUE_W  = 16;
	localparam int POS_W    = 10;
	localparam int RANK_W   = 10;
	localparam int RANK_MAX = 1023;

	localparam int DEPTH_DEF      = 1024;
	localparam int VALUE_BITS_DEF = 16;

	localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd2;

endpackage

`default_nettype wire

### hw/rtl/drt_if.sv
// Valid/ready channel interfaces for command items and rank result items.
`timescale 1ns / 1ps
`default_nettype none

interface drt_cmd_if;
	logic                      valid;
	logic                      ready;
	logic [drt_pkg::FUNC_W-1:0]  func;
	logic [drt_pkg::VALUE_W-1:0] value;
	logic [drt_pkg::POS_W-1:0]   position;

	modport source (output valid, func, value, position, input ready);
	modport sink   (input valid, func, value, position, output ready);
endinterface

interface drt_res_if;
	logic                       valid;
	logic                       ready;
	logic [drt_pkg::RANK_W-1:0] rank;
	logic                       position_valid;

	modport source (output valid, rank, position_valid, input ready);
	modport sink   (input valid, rank, position_valid, output ready);
endinterface

`default_nettype wire

### hw/rtl/dense_rank_table_core.sv
// Top level of the dense rank table: command sequencer over two table RAMs.
//
//  channel | dir | handshake    | payload
//  --------+-----+--------------+-------------------------------------
//  cmd     | in  | valid/ready  | func[1:0], value[15:0], position[9:0]
//  res     | out | valid/ready  | rank[9:0], position_valid
//
// Clear, an unused code and an append to an empty or full table complete in idle.
// Any other append shifts each of the k stored entries larger than the new value
// up one slot (one sorted-RAM shift per cycle), then writes the new value. A query
// reads the value at the position, then scans the m sorted entries below that value
// (at most DEPTH - 1) and registers the result in S_QOUT once the output register is free.
// An unfilled position goes straight to S_QOUT with rank zero.
// arst_n clears the fill count and control; RAM contents need no reset.
// cmd.ready is high only while idle; a finished result sits in the output
// register and the next item is taken while it waits to be consumed.
`timescale 1ns / 1ps
`default_nettype none

module dense_rank_table_core #(
	parameter int DEPTH      = drt_pkg::DEPTH_DEF,
	parameter int VALUE_BITS = drt_pkg::VALUE_BITS_DEF
) (
	input wire logic   clk,
	input wire logic   arst_n,
	drt_cmd_if.sink    cmd,
	drt_res_if.source  res
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int VB = VALUE_BITS;

	typedef enum logic [2:0] {
		S_IDLE,
		S_INS,
		S_INS_LAST,
		S_QVAL,
		S_QSCAN,
		S_QOUT
	} state_t;

	state_t state_q;

	// fill count and sequencer working registers
	logic [CW-1:0] count_q;
	logic [AW-1:0] pk_q;      // sorted slot being written during insert
	logic [AW-1:0] sk_q;      // sorted index under test during scan
	logic [VB-1:0] v_q;       // value being inserted, or queried value
	logic [VB-1:0] prev_q;    // last sorted value seen in scan
	logic [AW-1:0] r_q;       // distinct values below v_q so far
	logic [drt_pkg::RANK_W-1:0] rank_q;
	logic          pv_q;

	// output register
	logic                       res_valid_q;
	logic [drt_pkg::RANK_W-1:0] res_rank_q;
	logic                       res_pv_q;

	// RAM ports
	logic          v_we, s_we;
	logic [AW-1:0] v_waddr, v_raddr, s_waddr, s_raddr;
	logic [VB-1:0] v_wdata, v_rdata, s_wdata, s_rdata;

	logic [VB-1:0] val_in;
	logic          acc;
	logic          full;
	logic          pos_ok;
	logic          out_free;
	logic [drt_pkg::RANK_W-1:0] rank_sat;

	// value masked or widened to the table width
	generate
		if (VB <= drt_pkg::VALUE_W) begin : g_val_narrow
			assign val_in = cmd.value[VB-1:0];
		end else begin : g_val_wide
			assign val_in = {{(VB - drt_pkg::VALUE_W){1'b0}}, cmd.value};
		end
	endgenerate

	assign cmd.ready = (state_q == S_IDLE);
	assign acc       = cmd.valid && cmd.ready;
	assign full      = (count_q == CW'(DEPTH));
	assign pos_ok    = (32'(cmd.position) < 32'(count_q));
	assign out_free  = !res_valid_q || res.ready;

	// ranks beyond the output field saturate
	assign rank_sat = (32'(r_q) > 32'(drt_pkg::RANK_MAX)) ?
		drt_pkg::RANK_W'(drt_pkg::RANK_MAX) : drt_pkg::RANK_W'(r_q);

	assign res.valid          = res_valid_q;
	assign res.rank           = res_rank_q;
	assign res.position_valid = res_pv_q;

	// RAM address and write control
	always_comb begin
		v_we    = 1'b0;
		v_waddr = count_q[AW-1:0];
		v_wdata = val_in;
		v_raddr = AW'(cmd.position);
		s_we    = 1'b0;
		s_waddr = pk_q;
		s_wdata = v_q;
		s_raddr = '0;
		unique case (state_q)
			S_IDLE: begin
				if (acc && cmd.func == drt_pkg::FUNC_APPEND && !full) begin
					v_we = 1'b1;
					if (count_q == '0) begin
						s_we    = 1'b1;
						s_waddr = '0;
						s_wdata = val_in;
					end else begin
						s_raddr = AW'(count_q - CW'(1));
					end
				end
			end
			S_INS: begin
				// s_rdata holds sorted[pk_q - 1]
				s_we = 1'b1;
				if (s_rdata > v_q) begin
					s_wdata = s_rdata;
					s_raddr = pk_q - AW'(2);
				end
			end
			S_INS_LAST: begin
				s_we    = 1'b1;
				s_waddr = '0;
			end
			S_QVAL: begin
				s_raddr = '0;
			end
			S_QSCAN: begin
				s_raddr = sk_q + AW'(1);
			end
			S_QOUT: begin
			end
			default: begin
			end
		endcase
	end

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			// S_QOUT owns the output register in its own cycle
			if (res.ready && state_q != S_QOUT) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (acc) begin
						case (cmd.func)
							drt_pkg::FUNC_CLEAR: begin
								count_q <= '0;
							end
							drt_pkg::FUNC_APPEND: begin
								if (!full) begin
									count_q <= count_q + CW'(1);
									v_q     <= val_in;
									pk_q    <= count_q[AW-1:0];
									if (count_q != '0) begin
										state_q <= S_INS;
									end
								end
							end
							drt_pkg::FUNC_QUERY: begin
								if (pos_ok) begin
									state_q <= S_QVAL;
								end else begin
									rank_q  <= '0;
									pv_q    <= 1'b0;
									state_q <= S_QOUT;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_INS: begin
					if (s_rdata > v_q) begin
						if (pk_q == AW'(1)) begin
							state_q <= S_INS_LAST;
						end else begin
							pk_q <= pk_q - AW'(1);
						end
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_INS_LAST: begin
					state_q <= S_IDLE;
				end
				S_QVAL: begin
					v_q     <= v_rdata;
					sk_q    <= '0;
					r_q     <= '0;
					state_q <= S_QSCAN;
				end
				S_QSCAN: begin
					// the queried value is stored, so the scan always stops
					if (s_rdata >= v_q) begin
						rank_q  <= rank_sat;
						pv_q    <= 1'b1;
						state_q <= S_QOUT;
					end else begin
						if (sk_q == '0 || s_rdata != prev_q) begin
							r_q <= r_q + AW'(1);
						end
						prev_q <= s_rdata;
						sk_q   <= sk_q + AW'(1);
					end
				end
				S_QOUT: begin
					if (out_free) begin
						res_valid_q <= 1'b1;
						res_rank_q  <= rank_q;
						res_pv_q    <= pv_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	drt_ram #(
		.DEPTH (DEPTH),
		.WIDTH (VB)
	) u_value_ram (
		.clk   (clk),
		.we    (v_we),
		.waddr (v_waddr),
		.wdata (v_wdata),
		.raddr (v_raddr),
		.rdata (v_rdata)
	);

	drt_ram #(
		.DEPTH (DEPTH),
		.WIDTH (VB)
	) u_sorted_ram (
		.clk   (clk),
		.we    (s_we),
		.waddr (s_waddr),
		.wdata (s_wdata),
		.raddr (s_raddr),
		.rdata (s_rdata)
	);

endmodule

`default_nettype wire

### hw/rtl/drt_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module drt_ram #(
	parameter int DEPTH = drt_pkg::DEPTH_DEF,
	parameter int WIDTH = drt_pkg::VALUE_BITS_DEF,
	localparam int AW   = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

### hw/rtl/drt_checker.sv
// Port-level assertions for the dense rank table, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module drt_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          cmd_valid,
	input wire logic                          cmd_ready,
	input wire logic [drt_pkg::FUNC_W-1:0]    cmd_func,
	input wire logic                          res_valid,
	input wire logic                          res_ready,
	input wire logic [drt_pkg::RANK_W-1:0]    res_rank,
	input wire logic                          res_position_valid
);

	logic cmd_acc;
	assign cmd_acc = cmd_valid && cmd_ready;

	// a stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_rank)
			&& $stable(res_position_valid))
		else $error("result changed while stalled");

	// an unfilled position always reports rank zero
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_position_valid |-> res_rank == '0)
		else $error("invalid position with nonzero rank");

	// clear and append never raise a result
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_acc && cmd_func != drt_pkg::FUNC_QUERY && !res_valid |=> !res_valid)
		else $error("result without a query");

	// a query leaves the command side busy in the cycle after it is taken
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_acc && cmd_func == drt_pkg::FUNC_QUERY |=> !cmd_ready)
		else $error("command taken right after a query");

endmodule

bind dense_rank_table_core drt_checker u_drt_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.cmd_valid          (cmd.valid),
	.cmd_ready          (cmd.ready),
	.cmd_func           (cmd.func),
	.res_valid          (res.valid),
	.res_ready          (res.ready),
	.res_rank           (res.rank),
	.res_position_valid (res.position_valid)
);

`default_nettype wire
